// File: rtl/seven_segment_lcd_display_driver_unit_assert.svh
// ----------------------------------------------------------------------------
// Seven-segment LCD driver assertion macros
// Shorthand for clocked, reset-qualified properties on i_clk / i_rst_n.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_LCD_DISPLAY_DRIVER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_LCD_DISPLAY_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define SSLD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssld assertion failed");

// next-cycle implication
`define SSLD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssld assertion failed");

`endif

// File: rtl/ssld_pkg.sv
// ----------------------------------------------------------------------------
// ssld_pkg
// Types, codes and the digit segment table of the seven-segment LCD driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssld_pkg;

    localparam logic [1:0] TYPE_TEST   = 2'd0;
    localparam logic [1:0] TYPE_WAIT   = 2'd1;
    localparam logic [1:0] TYPE_ACT    = 2'd2;
    localparam logic [1:0] TYPE_NUMBER = 2'd3;

    localparam logic REG_TYPE   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [1:0]  TYPE_RST   = TYPE_WAIT;
    localparam logic [15:0] PERIOD_RST = 16'd1000;
    localparam logic [7:0]  NUM_MAX    = 8'd199;
    localparam logic [7:0]  HUNDRED    = 8'd100;
    localparam logic [7:0]  HUNDRED_SEG = 8'h80;
    localparam logic [7:0]  ACT_HIGH   = 8'b0111_0111;
    localparam logic [6:0]  ACT_LOW    = 7'b000_1001;

    typedef struct packed {
        logic [7:0] high;
        logic [6:0] low;
    } t_seg;

    function automatic logic [6:0] digit_seg(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0: s = 7'h3f;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5b;
            4'd3: s = 7'h4f;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6d;
            4'd6: s = 7'h7d;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7f;
            4'd9: s = 7'h6f;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ssld_in_if.sv
// ----------------------------------------------------------------------------
// ssld_in_if
// Input channel: timer tick or display value update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssld_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/ssld_out_if.sv
// ----------------------------------------------------------------------------
// ssld_out_if
// Result channel: common level, segment pins and tick count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssld_out_if;
    logic        valid;
    logic        ready;
    logic        common_level;
    logic [7:0]  pins_high_digit;
    logic [6:0]  pins_low_digit;
    logic [15:0] tick_total;

    modport source (output valid, output common_level, output pins_high_digit,
                    output pins_low_digit, output tick_total, input ready);
    modport sink   (input valid, input common_level, input pins_high_digit,
                    input pins_low_digit, input tick_total, output ready);
endinterface

`default_nettype wire

// File: rtl/ssld_num_dec.sv
// ----------------------------------------------------------------------------
// ssld_num_dec
// Decode a value 0..199 to hundreds segment and two seven-segment digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssld_num_dec (
    input  wire logic [7:0]   i_value,
    output ssld_pkg::t_seg    o_seg,
    output logic              o_ok
);

    logic        w_hundred;
    logic [6:0]  w_rem;
    logic [14:0] w_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens_x10;
    logic [3:0]  w_ones;
    logic [6:0]  w_tens_seg;

    assign o_ok      = (i_value <= ssld_pkg::NUM_MAX);
    assign w_hundred = (i_value >= ssld_pkg::HUNDRED);
    assign w_rem     = w_hundred ? 7'(i_value - ssld_pkg::HUNDRED) : i_value[6:0];

    // divide by ten: multiply by 205, drop 11 bits
    assign w_prod     = 15'(w_rem) * 15'd205;
    assign w_tens     = w_prod[14:11];
    assign w_tens_x10 = 7'({w_tens, 3'b000} + {2'b00, w_tens, 1'b0});
    assign w_ones     = 4'(w_rem - w_tens_x10);

    assign w_tens_seg = (w_hundred || w_rem >= 7'd10) ?
                        ssld_pkg::digit_seg(w_tens) : 7'h00;

    assign o_seg.high = (w_hundred ? ssld_pkg::HUNDRED_SEG : 8'h00) | {1'b0, w_tens_seg};
    assign o_seg.low  = ssld_pkg::digit_seg(w_ones);

endmodule

`default_nettype wire

// File: rtl/seven_segment_lcd_display_driver_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_lcd_display_driver_unit
// AC-driven LCD driver for one and a half digits plus a third digit.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_beat carries one beat per event: mode 0 is a timer tick, mode 1 a
//   display value update (number 0..199, or activity bits rx=bit0 tx=bit1).
//   Every accepted beat yields one beat on o_out_beat: the common level,
//   the segment pins (logical segment XOR common) and the tick count, all
//   taken after the beat's update.
//   The result appears in the cycle after acceptance. Throughput is one beat
//   per cycle unless the receiver stalls, set by the single result register.
//   When the receiver stalls, the result register holds and i_in_beat.ready
//   drops until it is taken; it stays high while the result is consumed.
//   The APB port writes display_type at 0x0 and anim_period at 0x4; a type
//   write re-initializes the animation. Configure only while idle.
//   Reset (synchronous, active low) selects the wait type, period 1000,
//   clears the segments and tick count and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_lcd_display_driver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ssld_in_if.sink          i_in_beat,
    ssld_out_if.source       o_out_beat,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [1:0]  r_type,   n_type;
    logic [15:0] r_period, n_period;
    logic        r_phase,  n_phase;
    logic [7:0]  r_high,   n_high;
    logic [6:0]  r_low,    n_low;
    logic [7:0]  r_ring,   n_ring;
    logic [1:0]  r_rb,     n_rb;
    logic [1:0]  r_tb,     n_tb;
    logic [15:0] r_cd,     n_cd;
    logic [15:0] r_tick,   n_tick;

    logic        r_out_valid;
    logic        r_out_common;
    logic [7:0]  r_out_high;
    logic [6:0]  r_out_low;
    logic [15:0] r_out_tick;

    logic           w_in_ready;
    logic           w_in_acc;
    logic           w_cfg_wr;
    logic [15:0]    w_cd_dec;
    logic [1:0]     w_rb_step;
    logic [1:0]     w_tb_step;
    logic [7:0]     w_ring_shl;
    ssld_pkg::t_seg w_num_seg;
    logic           w_num_ok;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == ssld_pkg::REG_PERIOD) ? {16'h0000, r_period}
                                                          : {30'h0, r_type};

    assign w_in_ready      = !r_out_valid || o_out_beat.ready;
    assign i_in_beat.ready = w_in_ready;
    assign w_in_acc        = i_in_beat.valid && w_in_ready;

    assign w_cd_dec   = r_cd - 16'd1;
    assign w_rb_step  = (r_rb != 2'd0) ? r_rb + 2'd1 : r_rb;
    assign w_tb_step  = (r_tb != 2'd0) ? r_tb + 2'd1 : r_tb;
    assign w_ring_shl = {r_ring[6:0], 1'b0};

    ssld_num_dec u_num_dec (
        .i_value (i_in_beat.value),
        .o_seg   (w_num_seg),
        .o_ok    (w_num_ok)
    );

    always_comb begin
        n_type   = r_type;
        n_period = r_period;
        n_phase  = r_phase;
        n_high   = r_high;
        n_low    = r_low;
        n_ring   = r_ring;
        n_rb     = r_rb;
        n_tb     = r_tb;
        n_cd     = r_cd;
        n_tick   = r_tick;

        if (w_in_acc) begin
            if (!i_in_beat.mode) begin
                n_phase = ~r_phase;
                n_tick  = r_tick + 16'd1;
                if (w_cd_dec == 16'd0) begin
                    n_cd = r_period;
                    case (r_type)
                        ssld_pkg::TYPE_WAIT: begin
                            n_low  = {3'b000, r_ring[3:0]};
                            n_high = {2'b00, r_ring[6:4], 2'b00, r_ring[7]};
                            n_ring = (w_ring_shl == 8'h00) ? 8'h01 : w_ring_shl;
                        end
                        ssld_pkg::TYPE_ACT: begin
                            n_rb  = w_rb_step;
                            n_tb  = w_tb_step;
                            n_low = {3'b000, (w_tb_step != 2'd2), 2'b00,
                                     (w_rb_step != 2'd2)};
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_cd = w_cd_dec;
                end
            end else begin
                case (r_type)
                    ssld_pkg::TYPE_NUMBER: begin
                        if (w_num_ok) begin
                            n_high = w_num_seg.high;
                            n_low  = w_num_seg.low;
                        end
                    end
                    ssld_pkg::TYPE_ACT: begin
                        if (r_rb == 2'd0 && i_in_beat.value[0]) begin
                            n_rb = 2'd1;
                        end
                        if (r_tb == 2'd0 && i_in_beat.value[1]) begin
                            n_tb = 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (w_cfg_wr) begin
            case (paddr[2])
                ssld_pkg::REG_TYPE: begin
                    n_type = pwdata[1:0];
                    case (pwdata[1:0])
                        ssld_pkg::TYPE_TEST: begin
                            n_high = 8'hff;
                            n_low  = 7'h7f;
                        end
                        ssld_pkg::TYPE_WAIT: begin
                            n_ring = 8'h01;
                        end
                        ssld_pkg::TYPE_ACT: begin
                            n_high = ssld_pkg::ACT_HIGH;
                            n_low  = ssld_pkg::ACT_LOW;
                            n_rb   = 2'd0;
                            n_tb   = 2'd0;
                        end
                        default: begin
                        end
                    endcase
                end
                ssld_pkg::REG_PERIOD: begin
                    n_period = pwdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type      <= ssld_pkg::TYPE_RST;
            r_period    <= ssld_pkg::PERIOD_RST;
            r_phase     <= 1'b0;
            r_high      <= 8'h00;
            r_low       <= 7'h00;
            r_ring      <= 8'h01;
            r_rb        <= 2'd0;
            r_tb        <= 2'd0;
            r_cd        <= ssld_pkg::PERIOD_RST;
            r_tick      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_type   <= n_type;
            r_period <= n_period;
            r_phase  <= n_phase;
            r_high   <= n_high;
            r_low    <= n_low;
            r_ring   <= n_ring;
            r_rb     <= n_rb;
            r_tb     <= n_tb;
            r_cd     <= n_cd;
            r_tick   <= n_tick;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out_beat.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_common <= n_phase;
            r_out_high   <= n_high ^ {8{n_phase}};
            r_out_low    <= n_low ^ {7{n_phase}};
            r_out_tick   <= n_tick;
        end
    end

    assign o_out_beat.valid           = r_out_valid;
    assign o_out_beat.common_level    = r_out_common;
    assign o_out_beat.pins_high_digit = r_out_high;
    assign o_out_beat.pins_low_digit  = r_out_low;
    assign o_out_beat.tick_total      = r_out_tick;

endmodule

`default_nettype wire

// File: rtl/ssld_checker.sv
// ----------------------------------------------------------------------------
// ssld_checker
// Port-level checks of the LCD driver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_lcd_display_driver_unit_assert.svh"

module ssld_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_mode,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_common,
    input wire logic [7:0]  i_out_high,
    input wire logic [6:0]  i_out_low,
    input wire logic [15:0] i_out_tick
);

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;

    `SSLD_ASSERT_NXT(a_stall_hold, w_out_stall, i_out_valid && $stable(i_out_high) && $stable(i_out_low) && $stable(i_out_tick))
    `SSLD_ASSERT_NXT(a_one_cycle_result, w_in_acc, i_out_valid)
    `SSLD_ASSERT_NXT(a_tick_advance, i_out_valid && w_in_acc && !i_in_mode, i_out_tick == 16'($past(i_out_tick) + 16'd1) && i_out_common != $past(i_out_common))
    `SSLD_ASSERT_NXT(a_update_keeps_time, i_out_valid && w_in_acc && i_in_mode, i_out_tick == $past(i_out_tick) && i_out_common == $past(i_out_common))

endmodule

bind seven_segment_lcd_display_driver_unit ssld_checker u_ssld_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_beat.valid),
    .i_in_ready   (i_in_beat.ready),
    .i_in_mode    (i_in_beat.mode),
    .i_out_valid  (o_out_beat.valid),
    .i_out_ready  (o_out_beat.ready),
    .i_out_common (o_out_beat.common_level),
    .i_out_high   (o_out_beat.pins_high_digit),
    .i_out_low    (o_out_beat.pins_low_digit),
    .i_out_tick   (o_out_beat.tick_total)
);

`default_nettype wire
